FILE: rtl/core/whole_word_phrase_matcher_unit_macros.svh
// Assertion helpers for the whole-word phrase matcher
`ifndef WHOLE_WORD_PHRASE_MATCHER_UNIT_MACROS_SVH
`define WHOLE_WORD_PHRASE_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define WWPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define WWPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/wwpm_pkg.sv
// ----------------------------------------------------------------------------
// wwpm_pkg
// Types, phrase table and helpers for the whole-word phrase matcher.
// ----------------------------------------------------------------------------
package wwpm_pkg;

    localparam int NUM_PHRASES    = 39;
    localparam int MAX_PHRASE_LEN = 22;
    localparam int TABLE_SIZE     = 39;
    localparam int SLOT_LIMIT     = 64;
    localparam int UNIT_W         = 16;
    localparam int PIDX_W         = 6;

    localparam logic [UNIT_W-1:0] UNIT_SPACE = 16'h0020;
    localparam logic [UNIT_W-1:0] UNIT_S     = 16'h0073;

    // end-check codes
    localparam logic [1:0] PEND_IDLE = 2'd0;
    localparam logic [1:0] PEND_WAIT = 2'd1;
    localparam logic [1:0] PEND_S    = 2'd2;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              last_unit;
    } in_item_t;

    typedef struct packed {
        logic              matched;
        logic [PIDX_W-1:0] phrase_index;
    } out_item_t;

    // one emitted unit as seen by the phrase lanes
    typedef struct packed {
        logic              emit;
        logic [UNIT_W-1:0] unit;
        logic              alnum;
        logic              prev_alnum;
        logic              flush;
    } emit_ctl_t;

    // phrases, right-aligned and zero padded: the last character is byte 0
    localparam logic [8*SLOT_LIMIT-1:0] PHRASE_TABLE [TABLE_SIZE] = '{
        "money transfer", "wire transfer", "bank transfer", {"wes", "tern un", "ion"},
        {"money", "gram"}, "send me money", "transfer the money", "gift card",
        {"itu", "nes card"}, {"goo", "gle pl", "ay card"}, {"ste", "am card"},
        {"ama", "zon card"},
        "investment opportunity", "crypto investment", "bitcoin investment",
        "guaranteed profit", "guaranteed return", "double your money",
        "high returns", "trading signal", "mining pool", "verification fee",
        "processing fee", "release fee", "activation fee", "customs fee",
        "unlock fee", "send the code", "send me the code", "verification code",
        "one-time code", "otp code", "seed phrase", "recovery phrase",
        "private key", "soulmate", "widower", "oil rig", "stranded abroad"
    };

    function automatic int phrase_len(int p);
        int n;
        n = 0;
        for (int b = 0; b < SLOT_LIMIT; b++)
        begin
            if (PHRASE_TABLE[p][8*b +: 8] != 8'h00)
                n++;
        end
        return n;
    endfunction

    // character i (from the start) of phrase p
    function automatic logic [7:0] phrase_char(int p, int i);
        return PHRASE_TABLE[p][8*(phrase_len(p)-1-i) +: 8];
    endfunction

    function automatic logic is_space_unit(logic [UNIT_W-1:0] u);
        return (u >= 16'h0009 && u <= 16'h000D) || u == 16'h0020 || u == 16'h0085 ||
               u == 16'h00A0 || u == 16'h1680 || (u >= 16'h2000 && u <= 16'h200A) ||
               u == 16'h2028 || u == 16'h2029 || u == 16'h202F || u == 16'h205F ||
               u == 16'h3000;
    endfunction

    function automatic logic is_alnum_unit(logic [UNIT_W-1:0] u);
        return (u >= 16'h0030 && u <= 16'h0039) || (u >= 16'h0061 && u <= 16'h007A) ||
               (u >= 16'h0041 && u <= 16'h005A) || (u >= 16'h0080 && !is_space_unit(u));
    endfunction

endpackage

FILE: rtl/core/wwpm_char_class.sv
// ----------------------------------------------------------------------------
// wwpm_char_class
// Folds case, collapses whitespace and classifies the emitted unit.
// ----------------------------------------------------------------------------
module wwpm_char_class
    import wwpm_pkg::*;
(
    input  logic              accept,
    input  in_item_t          item,
    input  logic              prev_space,
    input  logic              prev_alnum,
    output logic              unit_is_space,
    output emit_ctl_t         ctl
);

    logic [UNIT_W-1:0] folded;

    always_comb
    begin
        unit_is_space = is_space_unit(item.code_unit);
        folded = item.code_unit;
        if (item.code_unit >= 16'h0041 && item.code_unit <= 16'h005A)
            folded = item.code_unit + 16'h0020;
        ctl.emit       = accept && (!unit_is_space || !prev_space);
        ctl.unit       = unit_is_space ? UNIT_SPACE : folded;
        ctl.alnum      = !unit_is_space && is_alnum_unit(folded);
        ctl.prev_alnum = prev_alnum;
        ctl.flush      = accept && item.last_unit;
    end

endmodule

FILE: rtl/core/wwpm_phrase_bank.sv
// ----------------------------------------------------------------------------
// wwpm_phrase_bank
// Shift-and lanes, one per phrase, with word-end checks and hit bits.
// ----------------------------------------------------------------------------
module wwpm_phrase_bank
    import wwpm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  emit_ctl_t              ctl,
    output logic [NUM_PHRASES-1:0] final_hits
);

    for (genvar p = 0; p < NUM_PHRASES; p++)
    begin : g_lane
        if (p < TABLE_SIZE && phrase_len(p) >= 1 && phrase_len(p) <= MAX_PHRASE_LEN)
        begin : g_live
            localparam int LEN = phrase_len(p);

            logic [LEN-1:0] pm_reg, pm_next, adv;
            logic [1:0]     pend_reg, pend_next;
            logic           hit_reg, hit_next, hit_now;

            for (genvar i = 0; i < LEN; i++)
            begin : g_bit
                localparam logic [7:0] CH = phrase_char(p, i);
                if (i == 0)
                begin : g_head
                    assign adv[i] = !ctl.prev_alnum && ctl.unit == {8'h00, CH};
                end
                else
                begin : g_body
                    assign adv[i] = pm_reg[i-1] && ctl.unit == {8'h00, CH};
                end
            end

            always_comb
            begin
                hit_now   = 1'b0;
                pend_next = PEND_IDLE;
                case (pend_reg)
                    PEND_WAIT:
                    begin
                        if (!ctl.alnum)
                            hit_now = 1'b1;
                        else if (ctl.unit == UNIT_S)
                            pend_next = PEND_S;
                    end
                    PEND_S:
                        hit_now = !ctl.alnum;
                    default:
                        pend_next = PEND_IDLE;
                endcase
                pm_next = adv;
                if (adv[LEN-1])
                begin
                    pend_next        = PEND_WAIT;
                    pm_next[LEN-1]   = 1'b0;
                end
                hit_next = hit_reg || hit_now;
            end

            // pending end checks count as hits when the text ends
            assign final_hits[p] = ctl.emit ? (hit_next || pend_next != PEND_IDLE)
                                            : (hit_reg || pend_reg != PEND_IDLE);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    pm_reg   <= '0;
                    pend_reg <= PEND_IDLE;
                    hit_reg  <= 1'b0;
                end
                else if (ctl.flush)
                begin
                    pm_reg   <= '0;
                    pend_reg <= PEND_IDLE;
                    hit_reg  <= 1'b0;
                end
                else if (ctl.emit)
                begin
                    pm_reg   <= pm_next;
                    pend_reg <= pend_next;
                    hit_reg  <= hit_next;
                end
            end
        end
        else
        begin : g_dead
            assign final_hits[p] = 1'b0;
        end
    end

endmodule

FILE: rtl/core/whole_word_phrase_matcher_unit.sv
// Result: a result item appears in the output register in the cycle after the
//   item carrying last_unit is accepted.
// Throughput: one code unit per cycle; every phrase lane updates in the same
//   cycle, so the input only waits while a result sits stalled at the output.
// Reset: all match state cleared, leading whitespace skipping armed; the same
//   state is restored after every final unit.
// ----------------------------------------------------------------------------
// whole_word_phrase_matcher_unit
// Streams message text and reports the lowest whole-word phrase match.
// ----------------------------------------------------------------------------
`include "whole_word_phrase_matcher_unit_macros.svh"

module whole_word_phrase_matcher_unit
    import wwpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic                   accept;
    logic                   unit_is_space;
    logic                   prev_space_reg, prev_space_next;
    logic                   prev_alnum_reg, prev_alnum_next;
    logic                   out_valid_reg;
    out_item_t              out_data_reg, out_data_next;
    emit_ctl_t              ctl;
    logic [NUM_PHRASES-1:0] final_hits;

    // Hold the input only while a finished result is still being held back.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    wwpm_char_class u_class (
        .accept        (accept),
        .item          (in_data),
        .prev_space    (prev_space_reg),
        .prev_alnum    (prev_alnum_reg),
        .unit_is_space (unit_is_space),
        .ctl           (ctl)
    );

    wwpm_phrase_bank u_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .final_hits (final_hits)
    );

    // Pick the lowest hitting phrase; scan from the top so low indexes win.
    always_comb
    begin
        out_data_next.matched      = |final_hits;
        out_data_next.phrase_index = '0;
        for (int p = NUM_PHRASES - 1; p >= 0; p--)
        begin
            if (final_hits[p])
                out_data_next.phrase_index = PIDX_W'(p);
        end
    end

    // Track the last emitted unit; a final unit rearms leading-space skipping.
    always_comb
    begin
        prev_space_next = prev_space_reg;
        prev_alnum_next = prev_alnum_reg;
        if (ctl.flush)
        begin
            prev_space_next = 1'b1;
            prev_alnum_next = 1'b0;
        end
        else if (ctl.emit)
        begin
            prev_space_next = unit_is_space;
            prev_alnum_next = ctl.alnum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_space_reg <= 1'b1;
            prev_alnum_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prev_space_reg <= prev_space_next;
            prev_alnum_reg <= prev_alnum_next;
            if (ctl.flush)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Load the result item only on a final unit.
    always_ff @(posedge clk)
    begin
        if (ctl.flush)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `WWPM_ASSERT_NEXT(a_result_after_last, clk, rst_n, accept && in_data.last_unit, out_valid, "final unit gave no result")
    `WWPM_ASSERT_NOW(a_index_zero_when_none, clk, rst_n, out_valid && !out_data.matched, out_data.phrase_index == '0, "index set without a match")
    `WWPM_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, out_valid, "input stalled with empty output")
    `WWPM_ASSERT_NEXT(a_fresh_after_flush, clk, rst_n, ctl.flush, prev_space_reg && !prev_alnum_reg, "history not cleared after final unit")

endmodule
